>>> rtl/targa_rle_pixel_decoder_core_defines.svh
// assertion macros for the targa rle pixel decoder
`ifndef TARGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define TARGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
// checked while out of reset
`define TRD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define TRD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRD_ASSERT(name, prop, msg)
`define TRD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/tga_rle_pkg.sv
package tga_rle_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_REVERSED = 3'd4;

  // pixel formats, code 3 behaves as bgra
  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  localparam logic [12:0] RESET_WIDTH  = 13'd4;
  localparam logic [12:0] RESET_HEIGHT = 13'd1;
  localparam int          MIN_WIDTH    = 4;
  localparam int          MIN_HEIGHT   = 1;

  // largest literal count, counts above it start a run
  localparam logic [7:0] LITERAL_MAX = 8'd127;

  typedef struct packed {
    logic load;      // take the input word
    logic wrap;      // column past width: start the next row
    logic seg;       // build one row segment into the output register
    logic complete;  // row past height: mark the image complete
  } dp_cmd_t;

  typedef struct packed {
    logic pixel_ready;  // the offered word completes a pixel to emit
    logic emit_zero;    // no pixels left to emit
    logic col_over;     // column not below width
    logic row_over;     // row not below height
    logic out_last;     // held segment is the last for its word
  } dp_status_t;

endpackage

>>> rtl/tga_rle_ctrl.sv
module tga_rle_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    cfg_ready,
  input  tga_rle_pkg::dp_status_t status,
  output tga_rle_pkg::dp_cmd_t    cmd
);
  import tga_rle_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEG  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.pixel_ready) state_next = S_SEG;
        end
      end
      S_SEG: begin
        priority if (status.emit_zero) begin
          state_next = S_IDLE;
        end else if (status.col_over) begin
          cmd.wrap = 1'b1;
        end else if (status.row_over) begin
          cmd.complete = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.seg    = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = status.out_last ? S_IDLE : S_SEG;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  // register writes only with no byte on offer and nothing in flight
  assign cfg_ready = (state == S_IDLE) && !in_valid;

endmodule

>>> rtl/tga_rle_datapath.sv
module tga_rle_datapath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                           data_byte,
  input  logic                                 image_start,
  input  tga_rle_pkg::dp_cmd_t                 cmd,
  output tga_rle_pkg::dp_status_t              status,
  output logic [11:0]                          dest_row,
  output logic [11:0]                          start_col,
  output logic [7:0]                           run_length,
  output logic [7:0]                           red,
  output logic [7:0]                           green,
  output logic [7:0]                           blue,
  output logic [7:0]                           alpha,
  output logic                                 image_done,
  output logic                                 last
);
  import tga_rle_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [12:0] image_width, image_height;
  logic [1:0]  pixel_format;
  logic        rle_mode, rows_reversed;

  // decoder state
  logic          expect_count, expect_count_next;
  logic          packet_is_run, packet_is_run_next;
  logic [7:0]    pixels_left, pixels_left_next;
  logic [1:0]    byte_in_pixel, byte_in_pixel_next;
  logic [23:0]   color_bytes, color_bytes_next;
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          image_complete, image_complete_next;
  logic [7:0]    emit_left, emit_left_next;

  // clamped geometry
  logic [31:0] w_raw, h_raw, wc, hc;

  always_comb begin
    w_raw = 32'(image_width);
    h_raw = 32'(image_height);
    if (w_raw < 32'(MIN_WIDTH))       wc = 32'(MIN_WIDTH);
    else if (w_raw > 32'(MAX_WIDTH))  wc = 32'(MAX_WIDTH);
    else                              wc = w_raw;
    if (h_raw < 32'(MIN_HEIGHT))      hc = 32'(MIN_HEIGHT);
    else if (h_raw > 32'(MAX_HEIGHT)) hc = 32'(MAX_HEIGHT);
    else                              hc = h_raw;
  end

  // input word as seen after an optional image start
  logic        exp_c, run_c, cplt_c;
  logic [7:0]  left_c, left_dec;
  logic [1:0]  bip_c, bip_inc;
  logic [23:0] color_c;
  logic [31:0] full_color;
  logic        pix_done, is_count;
  logic [7:0]  count_pixels;

  assign exp_c   = image_start | expect_count;
  assign run_c   = image_start ? 1'b0 : packet_is_run;
  assign cplt_c  = image_start ? 1'b0 : image_complete;
  assign left_c  = image_start ? 8'd0 : pixels_left;
  assign bip_c   = image_start ? 2'd0 : byte_in_pixel;
  assign color_c = image_start ? 24'd0 : color_bytes;

  assign bip_inc    = bip_c + 2'd1;
  assign full_color = {8'd0, color_c} | (32'(data_byte) << {bip_c, 3'b000});
  assign is_count   = rle_mode & exp_c;
  always_comb begin
    unique case (pixel_format)
      FMT_GRAY: pix_done = 1'b1;
      FMT_BGR:  pix_done = (bip_inc == 2'd0) || (bip_inc >= 2'd3);
      default:  pix_done = (bip_inc == 2'd0);
    endcase
  end
  assign count_pixels = (data_byte > LITERAL_MAX) ? (data_byte - LITERAL_MAX)
                                                   : (data_byte + 8'd1);
  assign left_dec = (left_c != 8'd0) ? (left_c - 8'd1) : 8'd0;

  // segment arithmetic
  logic [31:0] col32, row32, rem32, sum32, row_inc, row_rev;
  logic [7:0]  seg_len, left_after;
  logic        row_end, seg_done, seg_last;

  assign col32      = 32'(column_count);
  assign row32      = 32'(row_count);
  assign rem32      = wc - col32;
  assign seg_len    = (rem32 < 32'(emit_left)) ? rem32[7:0] : emit_left;
  assign sum32      = col32 + 32'(seg_len);
  assign row_end    = (sum32 == wc);
  assign row_inc    = row32 + 32'd1;
  assign seg_done   = row_end && (row_inc >= hc);
  assign left_after = emit_left - seg_len;
  assign seg_last   = (left_after == 8'd0) || seg_done;
  assign row_rev    = hc - 32'd1 - row32;

  always_comb begin
    expect_count_next   = expect_count;
    packet_is_run_next  = packet_is_run;
    pixels_left_next    = pixels_left;
    byte_in_pixel_next  = byte_in_pixel;
    color_bytes_next    = color_bytes;
    column_count_next   = column_count;
    row_count_next      = row_count;
    image_complete_next = image_complete;
    emit_left_next      = emit_left;
    if (cmd.load) begin
      if (image_start) begin
        expect_count_next   = 1'b1;
        packet_is_run_next  = 1'b0;
        pixels_left_next    = 8'd0;
        byte_in_pixel_next  = 2'd0;
        color_bytes_next    = 24'd0;
        column_count_next   = '0;
        row_count_next      = '0;
        image_complete_next = 1'b0;
      end
      if (!cplt_c) begin
        if (is_count) begin
          packet_is_run_next = (data_byte > LITERAL_MAX);
          pixels_left_next   = count_pixels;
          expect_count_next  = 1'b0;
          byte_in_pixel_next = 2'd0;
          color_bytes_next   = 24'd0;
        end else if (!pix_done) begin
          color_bytes_next   = full_color[23:0];
          byte_in_pixel_next = bip_inc;
        end else begin
          byte_in_pixel_next = 2'd0;
          color_bytes_next   = 24'd0;
          if (!rle_mode) begin
            emit_left_next = 8'd1;
          end else if (run_c) begin
            emit_left_next    = left_c;
            pixels_left_next  = 8'd0;
            expect_count_next = 1'b1;
          end else begin
            emit_left_next   = 8'd1;
            pixels_left_next = left_dec;
            if (left_dec == 8'd0) expect_count_next = 1'b1;
          end
        end
      end
    end
    if (cmd.wrap) begin
      column_count_next = '0;
      row_count_next    = row_inc[RW-1:0];
    end
    if (cmd.seg) begin
      emit_left_next = left_after;
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = row_inc[RW-1:0];
      end else begin
        column_count_next = sum32[CW-1:0];
      end
      if (seg_done) image_complete_next = 1'b1;
    end
    if (cmd.complete) image_complete_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RESET_WIDTH;
      image_height   <= RESET_HEIGHT;
      pixel_format   <= FMT_BGR;
      rle_mode       <= 1'b0;
      rows_reversed  <= 1'b0;
      expect_count   <= 1'b1;
      packet_is_run  <= 1'b0;
      pixels_left    <= 8'd0;
      byte_in_pixel  <= 2'd0;
      color_bytes    <= 24'd0;
      column_count   <= '0;
      row_count      <= '0;
      image_complete <= 1'b0;
      emit_left      <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
          CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          CFG_PIXEL_FORMAT:  pixel_format  <= cfg_data[1:0];
          CFG_RLE_MODE:      rle_mode      <= cfg_data[0];
          CFG_ROWS_REVERSED: rows_reversed <= cfg_data[0];
          default: ;
        endcase
      end
      expect_count   <= expect_count_next;
      packet_is_run  <= packet_is_run_next;
      pixels_left    <= pixels_left_next;
      byte_in_pixel  <= byte_in_pixel_next;
      color_bytes    <= color_bytes_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      image_complete <= image_complete_next;
      emit_left      <= emit_left_next;
    end
  end

  // output word, held while presented
  always_ff @(posedge clk) begin
    if (cmd.load && status.pixel_ready) begin
      if (pixel_format == FMT_GRAY) begin
        red   <= full_color[7:0];
        green <= 8'd0;
        blue  <= 8'd0;
        alpha <= 8'd0;
      end else begin
        blue  <= full_color[7:0];
        green <= full_color[15:8];
        red   <= full_color[23:16];
        alpha <= (pixel_format == FMT_BGR) ? 8'd0 : full_color[31:24];
      end
    end
    if (cmd.seg) begin
      dest_row   <= rows_reversed ? row_rev[11:0] : row32[11:0];
      start_col  <= col32[11:0];
      run_length <= seg_len;
      image_done <= seg_done;
      last       <= seg_last;
    end
  end

  assign status.pixel_ready = !cplt_c && !is_count && pix_done;
  assign status.emit_zero   = (emit_left == 8'd0);
  assign status.col_over    = (col32 >= wc);
  assign status.row_over    = (row32 >= hc);
  assign status.out_last    = last;

endmodule

>>> rtl/targa_rle_pixel_decoder_core.sv
// a count byte or a byte inside a pixel is taken in idle and gives no word
// a completing byte moves to the segment state, which builds the first segment word
// each segment is built in the segment state and held in the output state while stalled
// a pixel byte thus gives one word per segment (a run split over rows adds segments)
// synchronous active-high reset restores the register defaults and clears decoder state
module targa_rle_pixel_decoder_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // input byte channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               image_start,
  // segment channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [11:0]                        dest_row,
  output logic [11:0]                        start_col,
  output logic [7:0]                         run_length,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic [7:0]                         alpha,
  output logic                               image_done,
  output logic                               last,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tga_rle_pkg::*;

`include "targa_rle_pixel_decoder_core_defines.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: idle takes a word, then the sequencer walks the run
  // one row segment at a time and parks each segment in the output register
  tga_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: packet parsing, pixel assembly, row/column counters,
  // segment split against the clamped width and height
  tga_rle_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_byte   (data_byte),
    .image_start (image_start),
    .cmd         (cmd),
    .status      (status),
    .dest_row    (dest_row),
    .start_col   (start_col),
    .run_length  (run_length),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .image_done  (image_done),
    .last        (last)
  );

  // one word in flight: never take a byte while a segment is on offer
  `TRD_ASSERT(a_no_overlap, !(out_valid && !in_stall), "input taken while segment offered")
  // a segment always carries at least one pixel
  `TRD_ASSERT(a_len_nonzero, out_valid |-> (run_length != 8'd0), "zero length segment")
  // the segment that finishes the image ends the sequence for its byte
  `TRD_ASSERT(a_done_is_last, (out_valid && image_done) |-> last, "image done without last")
  // a taken last segment returns the block to idle
  `TRD_ASSERT(a_last_to_idle, (out_valid && !out_stall && last) |=> !in_stall,
              "not idle after last segment")

endmodule

>>> dv/tga_segment_monitor.sv
module tga_segment_monitor #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               image_start,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [11:0]                        dest_row,
  input  logic [11:0]                        start_col,
  input  logic [7:0]                         run_length,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic [7:0]                         alpha,
  input  logic                               image_done,
  input  logic                               last,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                 pending,
  output int                                 mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import tga_rle_pkg::*;

  typedef struct packed {
    logic [11:0] dest_row;
    logic [11:0] start_col;
    logic [7:0]  run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        image_done;
    logic        last;
  } segment_t;

  segment_t segment_q[$];
  segment_t oldest;

  // register copies
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [1:0]  format_reg;
  logic        rle_reg;
  logic        reversed_reg;

  // decoder state
  logic        want_count;
  logic        in_run;
  logic [7:0]  packet_pixels;
  logic [1:0]  pixel_byte;
  logic [31:0] pixel_bytes;
  int          col;
  int          row_count;
  logic        done_flag;

  function automatic void clear_decoder();
    want_count    = 1'b1;
    in_run        = 1'b0;
    packet_pixels = '0;
    pixel_byte    = '0;
    pixel_bytes   = '0;
    col           = 0;
    row_count     = 0;
    done_flag     = 1'b0;
  endfunction

  function automatic int pixel_width();
    if (format_reg == FMT_GRAY) return 1;
    if (format_reg == FMT_BGR) return 3;
    return 4;
  endfunction

  // spread count copies of the held pixel over rows, returns segments made
  function automatic int emit_run(input int count);
    int w, h, seg_len, row, made;
    logic [7:0] r, g, b, a;
    segment_t s;
    made = 0;
    w = width_reg;
    h = height_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < MIN_HEIGHT) h = MIN_HEIGHT;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (format_reg == FMT_GRAY) begin
      r = pixel_bytes[7:0];
      g = '0;
      b = '0;
      a = '0;
    end else begin
      b = pixel_bytes[7:0];
      g = pixel_bytes[15:8];
      r = pixel_bytes[23:16];
      a = (format_reg == FMT_BGR) ? 8'h00 : pixel_bytes[31:24];
    end
    while (count > 0 && !done_flag) begin
      if (col >= w) begin
        col = 0;
        row_count++;
      end
      if (row_count >= h) begin
        done_flag = 1'b1;
        break;
      end
      seg_len = w - col;
      if (seg_len > count) seg_len = count;
      row = reversed_reg ? (h - 1 - row_count) : row_count;
      s.dest_row   = row[11:0];
      s.start_col  = col[11:0];
      s.run_length = seg_len[7:0];
      s.red        = r;
      s.green      = g;
      s.blue       = b;
      s.alpha      = a;
      s.image_done = 1'b0;
      s.last       = 1'b0;
      col   += seg_len;
      count -= seg_len;
      if (col == w) begin
        col = 0;
        row_count++;
        if (row_count >= h) begin
          done_flag = 1'b1;
          s.image_done = 1'b1;
        end
      end
      segment_q.insert(segment_q.size(), s);
      made++;
    end
    return made;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic restart);
    int made;
    segment_t tail;
    made = 0;
    if (restart) clear_decoder();
    if (done_flag) return;
    if (rle_reg && want_count) begin
      if (b > LITERAL_MAX) begin
        in_run = 1'b1;
        packet_pixels = b - LITERAL_MAX;
      end else begin
        in_run = 1'b0;
        packet_pixels = b + 8'd1;
      end
      want_count  = 1'b0;
      pixel_byte  = '0;
      pixel_bytes = '0;
      return;
    end
    pixel_bytes |= 32'(b) << (8 * pixel_byte);
    pixel_byte = pixel_byte + 2'd1;
    if (pixel_byte != 2'd0 && int'(pixel_byte) < pixel_width()) return;
    if (!rle_reg) begin
      made = emit_run(1);
    end else if (in_run) begin
      made = emit_run(int'(packet_pixels));
      packet_pixels = '0;
      want_count = 1'b1;
    end else begin
      made = emit_run(1);
      if (packet_pixels != 8'd0) packet_pixels--;
      if (packet_pixels == 8'd0) want_count = 1'b1;
    end
    pixel_byte  = '0;
    pixel_bytes = '0;
    if (made > 0) begin
      tail = segment_q.pop_back();
      tail.last = 1'b1;
      segment_q.insert(segment_q.size(), tail);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg    = RESET_WIDTH;
      height_reg   = RESET_HEIGHT;
      format_reg   = FMT_BGR;
      rle_reg      = 1'b0;
      reversed_reg = 1'b0;
      clear_decoder();
      segment_q.delete();
    end else begin
      // compare before predicting so a stray word is never matched to a fresh one
      if (out_valid && !out_stall) begin
        if (segment_q.size() == 0) begin
          $error("segment word with none expected: row %0d col %0d length %0d",
                 dest_row, start_col, run_length);
          mismatches++;
        end else begin
          oldest = segment_q.pop_front();
          check_field("dest_row", 32'(oldest.dest_row), 32'(dest_row));
          check_field("start_col", 32'(oldest.start_col), 32'(start_col));
          check_field("run_length", 32'(oldest.run_length), 32'(run_length));
          check_field("red", 32'(oldest.red), 32'(red));
          check_field("green", 32'(oldest.green), 32'(green));
          check_field("blue", 32'(oldest.blue), 32'(blue));
          check_field("alpha", 32'(oldest.alpha), 32'(alpha));
          check_field("image_done", 32'(oldest.image_done), 32'(image_done));
          check_field("last", 32'(oldest.last), 32'(last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:   width_reg    = cfg_data[12:0];
          CFG_IMAGE_HEIGHT:  height_reg   = cfg_data[12:0];
          CFG_PIXEL_FORMAT:  format_reg   = cfg_data[1:0];
          CFG_RLE_MODE:      rle_reg      = cfg_data[0];
          CFG_ROWS_REVERSED: reversed_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(data_byte, image_start);
    end
    pending = segment_q.size();
  end

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tga_rle_pkg::*;

  // format code 3 has no name in the package, it decodes as bgra
  localparam logic [1:0] FMT_SPARE = 2'd3;

  localparam int IDLE_PCT      = 37;
  localparam int RANDOM_BYTES  = 230;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES   = 300;
  // a word that gives no segment can still be in flight once the queue is empty
  localparam int SETTLE_CYCLES = 16;
  // worst byte is a 128 pixel run cut into 33 segments
  localparam int TAIL_CYCLES   = 80;
  // longest quiet time is the hold-off plus a few random stalls
  localparam int QUIET_LIMIT   = 3000;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic [7:0]            data_byte   = 8'h00;
  logic                  image_start = 1'b0;
  logic                  out_stall   = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [11:0]           dest_row;
  logic [11:0]           start_col;
  logic [7:0]            run_length;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [7:0]            alpha;
  logic                  image_done;
  logic                  last;
  logic                  cfg_ready;

  // from the segment monitor
  int pending;
  int mismatches;

  // idle chances, a hundred-scale, per side
  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;

  // hold-off requests from stimulus, served by the receiver process
  int hold_requests = 0;
  int holds_served  = 0;

  // register values as last written, used to shape well-formed streams
  logic [1:0] cur_format = FMT_BGR;
  logic       cur_rle    = 1'b0;

  int bytes_sent  = 0;
  int quiet_count = 0;

  targa_rle_pixel_decoder_core uut (.*);

  tga_segment_monitor segment_check (.*);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // segment receiver: random stalls, and a long hold-off when asked
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (out_idle_pct != 0) && ($urandom_range(99) < out_idle_pct);
    end
  end

  // watchdog on cycles with no word moving on any channel
  // sampled mid-cycle so the handshake is stable
  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // offer one byte word, after a random gap, and wait for it to be taken
  // valid stays high on return so a back-to-back word is offered without dropping valid
  task automatic send_byte(input logic [7:0] b, input logic restart);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    image_start <= restart;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    bytes_sent++;
  endtask

  // stop offering and wait until every predicted segment has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic settle(input int cycles);
    drain();
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // all five registers, only with the block idle
  task automatic configure(input int w, input int h, input logic [1:0] fmt,
                           input logic rle, input logic rev);
    settle(SETTLE_CYCLES);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_PIXEL_FORMAT, int'(fmt));
    write_reg(CFG_RLE_MODE, int'(rle));
    write_reg(CFG_ROWS_REVERSED, int'(rev));
    cfg_valid  <= 1'b0;
    cur_format = fmt;
    cur_rle    = rle;
  endtask

  // well-formed pixel stream for the current settings with random content,
  // sprinkled with stray bytes and restarts that break packets
  task automatic send_image(input int pixels, input logic fresh);
    int left, n, bpp;
    logic restart, is_run;
    restart = fresh;
    left = pixels;
    bpp = (cur_format == FMT_GRAY) ? 1 : (cur_format == FMT_BGR) ? 3 : 4;
    while (left > 0) begin
      if ($urandom_range(99) < 4) begin
        // stray word, sometimes restarting the image in mid-packet
        send_byte(8'($urandom), $urandom_range(99) < 30);
        restart = 1'b0;
      end
      is_run = 1'b0;
      n = 1;
      if (cur_rle) begin
        is_run = 1'($urandom_range(1));
        if (is_run) begin
          n = ($urandom_range(99) < 15) ? $urandom_range(1, 128) : $urandom_range(1, 8);
          send_byte(8'(int'(LITERAL_MAX) + n), restart);
        end else begin
          // the longest literal packet only where pixels are one byte
          n = (cur_format == FMT_GRAY && $urandom_range(99) < 3) ? 128 : $urandom_range(1, 6);
          send_byte(8'(n - 1), restart);
        end
        restart = 1'b0;
      end
      repeat (is_run ? 1 : n) begin
        repeat (bpp) begin
          send_byte(8'($urandom), restart);
          restart = 1'b0;
        end
      end
      left -= n;
    end
  endtask

  initial begin : stimulus
    int w, h, ew, eh, area, pixels, phase, stop_at, pick;
    logic [1:0] fmt;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gray, width and height under their minimum: a 4x1 image,
    // then one word past the end that must be dropped
    configure(0, 0, FMT_GRAY, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h5A, 1'b0);

    // spare format code as bgra, width 3 as 4, height over the max, rows reversed:
    // a run of 128 split into 32 row segments, one literal, a run of one
    configure(3, 8191, FMT_SPARE, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h80, 1'b0);

    // width over the max clamps to the widest row, run of 127 on one row
    configure(8191, 4096, FMT_BGR, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hC3, 1'b0);

    // back-pressure: receiver holds off while long runs keep coming,
    // so the block backs up and stalls its input
    in_idle_pct = 0;
    configure(4, 4096, FMT_GRAY, 1'b1, 1'b0);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 6; i++) begin
      send_byte(8'hFF, i == 0);
      send_byte(8'($urandom), 1'b0);
    end
    // sender pause in mid-image until every segment is back, then carry on
    in_idle_pct = IDLE_PCT;
    drain();
    send_image(10, 1'b0);

    // random phases: mostly small images, a few extreme settings,
    // sometimes continuing the previous image under new settings
    stop_at = bytes_sent + RANDOM_BYTES;
    phase = 0;
    while (bytes_sent < stop_at) begin
      // two phases with no idling on either side
      in_idle_pct  = (phase == 2 || phase == 3) ? 0 : IDLE_PCT;
      out_idle_pct = (phase == 2 || phase == 3) ? 0 : IDLE_PCT;
      pick = $urandom_range(99);
      if (pick < 85) w = $urandom_range(4, 10);
      else if (pick < 90) w = $urandom_range(0, 3);
      else if (pick < 95) w = 4096;
      else w = 8191;
      pick = $urandom_range(99);
      if (pick < 85) h = $urandom_range(1, 3);
      else if (pick < 90) h = 0;
      else if (pick < 95) h = 4096;
      else h = 8191;
      fmt = 2'($urandom_range(3));
      configure(w, h, fmt, 1'($urandom_range(1)), 1'($urandom_range(1)));
      ew = (w < MIN_WIDTH) ? MIN_WIDTH : (w > 4096) ? 4096 : w;
      eh = (h < MIN_HEIGHT) ? MIN_HEIGHT : (h > 4096) ? 4096 : h;
      area = ew * eh;
      if (area > 36) pixels = $urandom_range(4, 20);
      else if ($urandom_range(99) < 20) pixels = $urandom_range(1, area);
      else pixels = area + $urandom_range(0, 2);
      send_image(pixels, phase == 0 || $urandom_range(99) < 85);
      phase++;
    end

    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    settle(TAIL_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
